/* rtl/cbl_pkg.sv */
// Shared types and constants for the 3x3 convolution / batch norm / LeakyReLU block.
// Used by cbl_ctrl, cbl_datapath and conv3x3_batchnorm_leaky_relu; depends on nothing.
`default_nettype none

package cbl_pkg;

  // Default frame limits (line store depth and row counter range)
  localparam int DEFAULT_MAX_WIDTH  = 64;
  localparam int DEFAULT_MAX_HEIGHT = 64;

  // Fixed field widths
  localparam int PIX_W    = 8;
  localparam int COORD_W  = 6;
  localparam int CFG_IDX_W = 3;
  localparam int CFG_DATA_W = 24;
  localparam int SIZE_W   = 7;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_WEIGHTS_TOP    = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_WEIGHTS_MIDDLE = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_WEIGHTS_BOTTOM = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_NORM_SCALE     = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_NORM_BIAS      = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_FRAME_WIDTH    = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_FRAME_HEIGHT   = 3'd6;

  // Configuration reset values
  localparam logic [7:0]        RESET_NORM_SCALE   = 8'd64;
  localparam logic [7:0]        RESET_NORM_BIAS    = 8'd0;
  localparam logic [SIZE_W-1:0] RESET_FRAME_WIDTH  = 7'd8;
  localparam logic [SIZE_W-1:0] RESET_FRAME_HEIGHT = 7'd8;

  // Center selection: previous row/column or current one
  localparam logic SEL_PREV = 1'b0;
  localparam logic SEL_CUR  = 1'b1;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_LOAD,
    ST_MAC,
    ST_SCALE,
    ST_EMIT
  } state_t;

  // Commands from controller to datapath
  typedef struct packed {
    logic       capture;   // input beat accepted: latch pixel and position, read line stores
    logic       load;      // shift window, write line stores, advance position
    logic       mac_en;    // accumulate one kernel tap
    logic       scale_en;  // apply batch norm scale
    logic       emit;      // write result into output register
    logic       last;      // final result of this input beat
    logic       row_sel;
    logic       col_sel;
    logic [1:0] kr;
    logic [1:0] kc;
  } cmd_t;

  // Status from datapath to controller
  typedef struct packed {
    logic row_prev;  // a center exists on the row above
    logic row_cur;   // a center exists on the current row (last row)
    logic col_prev;  // a center exists on the column to the left
    logic col_cur;   // a center exists on the current column (last column)
    logic out_free;  // output register can take a result this cycle
  } status_t;

endpackage

`default_nettype wire

/* rtl/cbl_ctrl.sv */
// Controller FSM: sequences window load, tap accumulation, scaling and result beats.
// Depends on cbl_pkg for state, command and status types.
`default_nettype none

module cbl_ctrl
  import cbl_pkg::*;
(
  input  wire logic    clk,
  input  wire logic    rst,
  input  wire logic    in_valid,
  output logic         in_ready,
  input  wire status_t status,
  output cmd_t         cmd
);

  state_t     state, state_next;
  logic       row_sel, row_sel_next;
  logic       col_sel, col_sel_next;
  logic [1:0] kr, kr_next;
  logic [1:0] kc, kc_next;

  logic any_center;
  logic first_row, first_col;
  logic next_col, next_row;

  // Center enumeration: rows outer, columns inner, in raster order
  assign any_center = (status.row_prev | status.row_cur) & (status.col_prev | status.col_cur);
  assign first_row  = status.row_prev ? SEL_PREV : SEL_CUR;
  assign first_col  = status.col_prev ? SEL_PREV : SEL_CUR;
  assign next_col   = (col_sel == SEL_PREV) & status.col_cur;
  assign next_row   = (row_sel == SEL_PREV) & status.row_cur;

  // State and counter registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= ST_IDLE;
      row_sel <= SEL_PREV;
      col_sel <= SEL_PREV;
      kr      <= 2'd0;
      kc      <= 2'd0;
    end else begin
      state   <= state_next;
      row_sel <= row_sel_next;
      col_sel <= col_sel_next;
      kr      <= kr_next;
      kc      <= kc_next;
    end
  end

  // Next state and commands
  always_comb begin
    state_next   = state;
    row_sel_next = row_sel;
    col_sel_next = col_sel;
    kr_next      = kr;
    kc_next      = kc;
    in_ready     = 1'b0;
    cmd          = '0;
    cmd.row_sel  = row_sel;
    cmd.col_sel  = col_sel;
    cmd.kr       = kr;
    cmd.kc       = kc;
    cmd.last     = ~(next_col | next_row);

    case (state)
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.capture = 1'b1;
          state_next  = ST_LOAD;
        end
      end
      ST_LOAD: begin
        cmd.load     = 1'b1;
        row_sel_next = first_row;
        col_sel_next = first_col;
        kr_next      = 2'd0;
        kc_next      = 2'd0;
        state_next   = any_center ? ST_MAC : ST_IDLE;
      end
      ST_MAC: begin
        cmd.mac_en = 1'b1;
        if (kc == 2'd2) begin
          kc_next = 2'd0;
          if (kr == 2'd2) begin
            kr_next    = 2'd0;
            state_next = ST_SCALE;
          end else begin
            kr_next = kr + 2'd1;
          end
        end else begin
          kc_next = kc + 2'd1;
        end
      end
      ST_SCALE: begin
        cmd.scale_en = 1'b1;
        state_next   = ST_EMIT;
      end
      ST_EMIT: begin
        // Hold until the output register frees up
        if (status.out_free) begin
          cmd.emit = 1'b1;
          if (next_col) begin
            col_sel_next = SEL_CUR;
            state_next   = ST_MAC;
          end else if (next_row) begin
            row_sel_next = SEL_CUR;
            col_sel_next = first_col;
            state_next   = ST_MAC;
          end else begin
            state_next = ST_IDLE;
          end
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

endmodule

`default_nettype wire

/* rtl/cbl_datapath.sv */
// Datapath: config registers, line stores, 3x3 window, MAC, batch norm, LeakyReLU, output register.
// Depends on cbl_pkg for command/status types and register indexes.
`default_nettype none

module cbl_datapath
  import cbl_pkg::*;
#(
  parameter int MAX_WIDTH  = DEFAULT_MAX_WIDTH,
  parameter int MAX_HEIGHT = DEFAULT_MAX_HEIGHT
) (
  input  wire logic                         clk,
  input  wire logic                         rst,
  input  wire logic                         cfg_write,
  input  wire logic [CFG_IDX_W-1:0]         cfg_index,
  input  wire logic [CFG_DATA_W-1:0]        cfg_data,
  input  wire logic signed [PIX_W-1:0]      pixel_in,
  input  wire cmd_t                         cmd,
  output status_t                           status,
  output logic                              out_valid,
  input  wire logic                         out_ready,
  output logic signed [PIX_W-1:0]           pixel_out,
  output logic [COORD_W-1:0]                out_row,
  output logic [COORD_W-1:0]                out_col,
  output logic                              last_of_run
);

  localparam int CW = $clog2(MAX_WIDTH);
  localparam int RW = $clog2(MAX_HEIGHT);

  // Configuration registers
  logic [CFG_DATA_W-1:0] weights_top_row, weights_middle_row, weights_bottom_row;
  logic signed [7:0]     norm_scale, norm_bias;
  logic [SIZE_W-1:0]     frame_width, frame_height;

  always_ff @(posedge clk) begin
    if (rst) begin
      weights_top_row    <= '0;
      weights_middle_row <= '0;
      weights_bottom_row <= '0;
      norm_scale         <= RESET_NORM_SCALE;
      norm_bias          <= RESET_NORM_BIAS;
      frame_width        <= RESET_FRAME_WIDTH;
      frame_height       <= RESET_FRAME_HEIGHT;
    end else if (cfg_write) begin
      case (cfg_index)
        REG_WEIGHTS_TOP:    weights_top_row    <= cfg_data;
        REG_WEIGHTS_MIDDLE: weights_middle_row <= cfg_data;
        REG_WEIGHTS_BOTTOM: weights_bottom_row <= cfg_data;
        REG_NORM_SCALE:     norm_scale         <= cfg_data[7:0];
        REG_NORM_BIAS:      norm_bias          <= cfg_data[7:0];
        REG_FRAME_WIDTH:    frame_width        <= cfg_data[SIZE_W-1:0];
        REG_FRAME_HEIGHT:   frame_height       <= cfg_data[SIZE_W-1:0];
        default: ;
      endcase
    end
  end

  // Clamp frame size: zero acts as one, large values saturate
  logic [CW-1:0] last_col;
  logic [RW-1:0] last_row;

  always_comb begin
    if (frame_width == '0) begin
      last_col = '0;
    end else if (int'(frame_width) > MAX_WIDTH) begin
      last_col = CW'(MAX_WIDTH - 1);
    end else begin
      last_col = CW'(frame_width - 7'd1);
    end
    if (frame_height == '0) begin
      last_row = '0;
    end else if (int'(frame_height) > MAX_HEIGHT) begin
      last_row = RW'(MAX_HEIGHT - 1);
    end else begin
      last_row = RW'(frame_height - 7'd1);
    end
  end

  // Position of the next pixel, clamped to the current frame size
  logic [CW-1:0] col_count, cur_col, item_c;
  logic [RW-1:0] row_count, cur_row, item_r;
  logic signed [PIX_W-1:0] pix_q;

  assign cur_col = (col_count > last_col) ? last_col : col_count;
  assign cur_row = (row_count > last_row) ? last_row : row_count;

  always_ff @(posedge clk) begin
    if (rst) begin
      col_count <= '0;
      row_count <= '0;
    end else if (cmd.load) begin
      if (item_c == last_col) begin
        col_count <= '0;
        row_count <= (item_r == last_row) ? '0 : item_r + 1'b1;
      end else begin
        col_count <= item_c + 1'b1;
        row_count <= item_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      pix_q  <= pixel_in;
      item_c <= cur_col;
      item_r <= cur_row;
    end
  end

  // Line stores: read at the accepted beat, write back during load
  logic [PIX_W-1:0] older_mem [MAX_WIDTH];
  logic [PIX_W-1:0] newer_mem [MAX_WIDTH];
  logic [PIX_W-1:0] older_rd, newer_rd;

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      older_rd <= older_mem[cur_col];
      newer_rd <= newer_mem[cur_col];
    end
    if (cmd.load) begin
      older_mem[item_c] <= newer_rd;
      newer_mem[item_c] <= pix_q;
    end
  end

  // 3x3 window: clear at column zero, shift left, load new column
  logic [PIX_W-1:0] win [3][3];

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      for (int k = 0; k < 3; k++) begin
        win[k][0] <= (item_c == '0) ? '0 : win[k][1];
        win[k][1] <= (item_c == '0) ? '0 : win[k][2];
      end
      win[0][2] <= older_rd;
      win[1][2] <= newer_rd;
      win[2][2] <= pix_q;
    end
  end

  // Status for center enumeration
  assign status.row_prev = (item_r != '0);
  assign status.row_cur  = (item_r == last_row);
  assign status.col_prev = (item_c != '0);
  assign status.col_cur  = (item_c == last_col);
  assign status.out_free = ~out_valid | out_ready;

  // Tap selection: window row/column of kernel tap for the chosen center
  logic [1:0]              wr, wc;
  logic                    row_ok, col_ok;
  logic signed [PIX_W-1:0] tap, wt;
  logic [CFG_DATA_W-1:0]   wrow;
  logic signed [15:0]      prod;
  logic [7:0]              term;
  logic [7:0]              acc;

  assign wr = cmd.kr + {1'b0, cmd.row_sel};
  assign wc = cmd.kc + {1'b0, cmd.col_sel};

  // Neighbor inside the frame: position + window index - 2 must not be negative
  assign row_ok = ({1'b0, item_r} + (RW+1)'(wr)) >= (RW+1)'(2);
  assign col_ok = ({1'b0, item_c} + (CW+1)'(wc)) >= (CW+1)'(2);

  always_comb begin
    case ({wr, wc})
      4'b0000: tap = win[0][0];
      4'b0001: tap = win[0][1];
      4'b0010: tap = win[0][2];
      4'b0100: tap = win[1][0];
      4'b0101: tap = win[1][1];
      4'b0110: tap = win[1][2];
      4'b1000: tap = win[2][0];
      4'b1001: tap = win[2][1];
      4'b1010: tap = win[2][2];
      default: tap = '0;
    endcase
    case (cmd.kr)
      2'd0:    wrow = weights_top_row;
      2'd1:    wrow = weights_middle_row;
      default: wrow = weights_bottom_row;
    endcase
    case (cmd.kc)
      2'd0:    wt = wrow[7:0];
      2'd1:    wt = wrow[15:8];
      default: wt = wrow[23:16];
    endcase
  end

  // Only the low byte of the sum matters, so accumulate in 8 bits
  assign prod = tap * wt;
  assign term = (row_ok & col_ok) ? prod[7:0] : 8'd0;

  always_ff @(posedge clk) begin
    if (cmd.mac_en) begin
      acc <= ((cmd.kr == 2'd0 && cmd.kc == 2'd0) ? 8'd0 : acc) + term;
    end
  end

  // Batch norm scale: Q7 product, arithmetic shift right by seven
  logic signed [15:0] scale_prod;
  logic signed [8:0]  scaled;

  assign scale_prod = $signed(acc) * norm_scale;

  always_ff @(posedge clk) begin
    if (cmd.scale_en) begin
      scaled <= scale_prod[15:7];
    end
  end

  // Bias and LeakyReLU
  logic signed [9:0]       bn;
  logic signed [PIX_W-1:0] act;

  assign bn  = 10'(scaled) + 10'(norm_bias);
  assign act = bn[9] ? {bn[9], bn[9:3]} : bn[7:0];

  // Output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.emit) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      pixel_out   <= act;
      out_row     <= COORD_W'((cmd.row_sel == SEL_CUR) ? item_r : item_r - 1'b1);
      out_col     <= COORD_W'((cmd.col_sel == SEL_CUR) ? item_c : item_c - 1'b1);
      last_of_run <= cmd.last;
    end
  end

endmodule

`default_nettype wire

/* rtl/conv3x3_batchnorm_leaky_relu.sv */
// Top level: 3x3 convolution with batch norm and LeakyReLU over a raster pixel stream.
// Instantiates cbl_ctrl and cbl_datapath; depends on cbl_pkg.
//
//   Channel  | Handshake              | Payload
//   ---------+------------------------+-------------------------------------------
//   input    | in_valid / in_ready    | pixel_in
//   output   | out_valid / out_ready  | pixel_out, out_row, out_col, last_of_run
//   config   | cfg_write              | cfg_index, cfg_data
//
// An input beat is captured and loaded into the window; then for each of its results
// (0 to 4 results) one shared 8x8 multiplier walks the nine kernel taps, then a scale
// step and an emit step follow. The next beat is accepted once the previous one has
// handed its last result to the output register, even if that result is still waiting
// to be taken. A stalled output holds the sequencer in its emit step. Synchronous reset
// clears position counters and restores config defaults; line stores are not cleared.
`default_nettype none

module conv3x3_batchnorm_leaky_relu
  import cbl_pkg::*;
#(
  parameter int MAX_WIDTH  = DEFAULT_MAX_WIDTH,
  parameter int MAX_HEIGHT = DEFAULT_MAX_HEIGHT
) (
  input  wire logic                    clk,
  input  wire logic                    rst,
  input  wire logic                    cfg_write,
  input  wire logic [CFG_IDX_W-1:0]    cfg_index,
  input  wire logic [CFG_DATA_W-1:0]   cfg_data,
  input  wire logic                    in_valid,
  output logic                         in_ready,
  input  wire logic signed [PIX_W-1:0] pixel_in,
  output logic                         out_valid,
  input  wire logic                    out_ready,
  output logic signed [PIX_W-1:0]      pixel_out,
  output logic [COORD_W-1:0]           out_row,
  output logic [COORD_W-1:0]           out_col,
  output logic                         last_of_run
);

  cmd_t    cmd;
  status_t status;

  cbl_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .status   (status),
    .cmd      (cmd)
  );

  cbl_datapath #(
    .MAX_WIDTH  (MAX_WIDTH),
    .MAX_HEIGHT (MAX_HEIGHT)
  ) u_datapath (
    .clk         (clk),
    .rst         (rst),
    .cfg_write   (cfg_write),
    .cfg_index   (cfg_index),
    .cfg_data    (cfg_data),
    .pixel_in    (pixel_in),
    .cmd         (cmd),
    .status      (status),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .pixel_out   (pixel_out),
    .out_row     (out_row),
    .out_col     (out_col),
    .last_of_run (last_of_run)
  );

endmodule

`default_nettype wire
